/* src/rrl_pkg.sv */
// Shared types and constants for the request rate limiter.
// No dependencies; the top level uses these by scoped name.
package rrl_pkg;

    localparam int SERVICE_SLOTS = 8;
    localparam int SLOT_IDX_W    = $clog2(SERVICE_SLOTS);

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int SPACING_W = 16;
    localparam int CAP_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0]  WINDOW_MS = TIME_W'(1000);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_SPACING = 2'd1,
        VERDICT_CAP     = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SPACING    = 1'b0,
        CFG_MAX_PER_SECOND = 1'b1
    } t_cfg_index;

endpackage

/* src/request_rate_limiter_top.sv */
// Request rate limiter: per-service spacing table plus a one-second request cap.
// Depends on rrl_pkg (types, widths, constants).
//
// Each input beat carries a service id and a millisecond tick. A small sequencer
// drives one shared 32-bit subtract/compare unit: with spacing enabled it walks
// the slot table one slot a cycle from slot 0 (the walk stops at the first
// match), then with the cap enabled and no spacing reject it runs the window
// check and then the saturating count, and last it loads the verdict register
// once that is free. The walk covers the slots up to the first match, or all
// SERVICE_SLOTS when the id is new. The input side stalls from the accepting
// edge until the verdict is loaded; a finished verdict can wait in the output
// register while the next request is taken. Verdict: 0 accepted, 1 rejected by
// spacing, 2 rejected by the per-second cap. Slots reset to id 0 / time 0 and
// carry no valid bit, so id 0 matches slot 0 after reset. Configuration writes
// take effect at once and are meant to happen while the block is idle.
module request_rate_limiter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [rrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rrl_pkg::ID_W-1:0]       i_service_id,
    input  logic [rrl_pkg::TIME_W-1:0]     i_now_ms,
    // verdict channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_verdict
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,     // one slot per cycle through the shared comparator
        S_WIN,      // window restart check
        S_CNT,      // saturating count and cap compare
        S_OUT       // load verdict register once it is free
    } t_state;

    localparam logic [rrl_pkg::SLOT_IDX_W-1:0] LAST_SLOT =
        rrl_pkg::SLOT_IDX_W'(rrl_pkg::SERVICE_SLOTS - 1);

    // configuration
    logic [rrl_pkg::SPACING_W-1:0] r_min_spacing;
    logic [rrl_pkg::CAP_W-1:0]     r_max_per_sec;

    // slot table
    logic [rrl_pkg::ID_W-1:0]   r_slot_service [rrl_pkg::SERVICE_SLOTS];
    logic [rrl_pkg::TIME_W-1:0] r_slot_seen    [rrl_pkg::SERVICE_SLOTS];
    logic [rrl_pkg::SLOT_IDX_W-1:0] r_insert_ptr;

    // window state
    logic [rrl_pkg::TIME_W-1:0]  r_window_start;
    logic [rrl_pkg::COUNT_W-1:0] r_window_count;

    // sequencer and request latch
    t_state                         r_state;
    logic [rrl_pkg::SLOT_IDX_W-1:0] r_idx;
    logic [rrl_pkg::ID_W-1:0]       r_id;
    logic [rrl_pkg::TIME_W-1:0]     r_now;
    rrl_pkg::t_verdict              r_pend;

    // output register
    logic              r_out_valid;
    rrl_pkg::t_verdict r_verdict;

    // shared subtract unit: operand B picks slot time or window start
    logic [rrl_pkg::TIME_W-1:0]  sub_b;
    logic [rrl_pkg::TIME_W-1:0]  sub_diff;
    logic                        slot_match;
    logic                        gap_short;
    logic                        win_expired;
    logic [rrl_pkg::COUNT_W-1:0] count_inc;
    logic                        in_take;
    logic                        out_free;

    always_comb begin
        sub_b       = (r_state == S_WIN) ? r_window_start : r_slot_seen[r_idx];
        sub_diff    = r_now - sub_b;
        slot_match  = (r_slot_service[r_idx] == r_id);
        gap_short   = (sub_diff < {{(rrl_pkg::TIME_W-rrl_pkg::SPACING_W){1'b0}},
                                   r_min_spacing});
        win_expired = (sub_diff > rrl_pkg::WINDOW_MS);
        count_inc   = (r_window_count != rrl_pkg::COUNT_MAX) ?
                      r_window_count + rrl_pkg::COUNT_W'(1) : r_window_count;
        in_take     = i_in_valid && (r_state == S_IDLE);
        out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_spacing  <= '0;
            r_max_per_sec  <= '0;
            for (int k = 0; k < rrl_pkg::SERVICE_SLOTS; k++) begin
                r_slot_service[k] <= '0;
                r_slot_seen[k]    <= '0;
            end
            r_insert_ptr   <= '0;
            r_window_start <= '0;
            r_window_count <= '0;
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_pend         <= rrl_pkg::VERDICT_ACCEPT;
            r_out_valid    <= 1'b0;
            r_verdict      <= rrl_pkg::VERDICT_ACCEPT;
        end else begin
            if (i_cfg_we) begin
                unique case (rrl_pkg::t_cfg_index'(i_cfg_index))
                    rrl_pkg::CFG_MIN_SPACING:    r_min_spacing <= i_cfg_data;
                    rrl_pkg::CFG_MAX_PER_SECOND:
                        r_max_per_sec <= i_cfg_data[rrl_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end

            // in S_OUT a drained register is refilled below instead
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_id   <= i_service_id;
                        r_now  <= i_now_ms;
                        r_idx  <= '0;
                        r_pend <= rrl_pkg::VERDICT_ACCEPT;
                        if (r_min_spacing != '0) begin
                            r_state <= S_SCAN;
                        end else if (r_max_per_sec != '0) begin
                            r_state <= S_WIN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (slot_match && gap_short) begin
                        r_pend  <= rrl_pkg::VERDICT_SPACING;
                        r_state <= S_OUT;
                    end else if (slot_match || r_idx == LAST_SLOT) begin
                        if (slot_match) begin
                            r_slot_seen[r_idx] <= r_now;
                        end else begin
                            // new id: round-robin replacement
                            r_slot_service[r_insert_ptr] <= r_id;
                            r_slot_seen[r_insert_ptr]    <= r_now;
                            r_insert_ptr <= (r_insert_ptr == LAST_SLOT) ?
                                            '0 : r_insert_ptr + 1'b1;
                        end
                        r_state <= (r_max_per_sec != '0) ? S_WIN : S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WIN: begin
                    if (win_expired) begin
                        r_window_start <= r_now;
                        r_window_count <= '0;
                    end
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    r_window_count <= count_inc;
                    if (count_inc > {1'b0, r_max_per_sec}) begin
                        r_pend <= rrl_pkg::VERDICT_CAP;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_verdict   <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---- assertions ----
    a_spacing_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == rrl_pkg::VERDICT_SPACING) |-> (r_min_spacing != '0))
        else $error("spacing reject while spacing check disabled");

    a_cap_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == rrl_pkg::VERDICT_CAP) |-> (r_max_per_sec != '0))
        else $error("cap reject while cap disabled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken without entering busy state");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == rrl_pkg::VERDICT_ACCEPT ||
                         o_verdict == rrl_pkg::VERDICT_SPACING ||
                         o_verdict == rrl_pkg::VERDICT_CAP))
        else $error("undefined verdict code on output");

endmodule

/* sim/request_rate_limiter_top_tb.sv */
// Self-checking testbench for request_rate_limiter_top: a verdict predictor, random idling.
// Depends on rrl_pkg and request_rate_limiter_top; it needs no other file.
// It has directed corner cases, then random request traffic, then an unbroken burst past the cap.
module request_rate_limiter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rrl_pkg::ID_W-1:0]   id;
        logic [rrl_pkg::TIME_W-1:0] stamp;
    } t_req;

    // ------------------------------------------------------------------
    // DUT hookup; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    rrl_pkg::t_cfg_index            cfg_index = rrl_pkg::CFG_MIN_SPACING;
    logic [rrl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic [rrl_pkg::ID_W-1:0]       in_id     = '0;
    logic [rrl_pkg::TIME_W-1:0]     in_stamp  = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [1:0]                     verdict;

    request_rate_limiter_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_service_id (in_id),
        .i_now_ms     (in_stamp),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_verdict    (verdict)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_req              pending_q[$];     // requests not yet put on the wire
    rrl_pkg::t_verdict verdict_q[$];     // predicted verdicts, oldest first
    int unsigned reqs_queued   = 0;
    int unsigned verdicts_seen = 0;
    int unsigned mismatches    = 0;
    logic        req_beat_taken = 1'b0;  // request beat accepted at the last rising edge
    logic        sender_idles   = 1'b0;
    logic        receiver_idles = 1'b0;
    logic [rrl_pkg::TIME_W-1:0] tick;

    // ------------------------------------------------------------------
    // Verdict predictor: own copy of the slot table, window and registers
    // ------------------------------------------------------------------
    logic [rrl_pkg::ID_W-1:0]       seen_id  [rrl_pkg::SERVICE_SLOTS];
    logic [rrl_pkg::TIME_W-1:0]     seen_at  [rrl_pkg::SERVICE_SLOTS];
    logic [rrl_pkg::SLOT_IDX_W-1:0] next_slot;
    logic [rrl_pkg::TIME_W-1:0]     win_start;
    logic [rrl_pkg::COUNT_W-1:0]    win_count;
    logic [rrl_pkg::SPACING_W-1:0]  spacing_cfg;
    logic [rrl_pkg::CAP_W-1:0]      cap_cfg;

    function automatic rrl_pkg::t_verdict judge_request(
        input logic [rrl_pkg::ID_W-1:0]   id,
        input logic [rrl_pkg::TIME_W-1:0] stamp);
        logic                       hit;
        logic [rrl_pkg::TIME_W-1:0] gap;
        hit = 1'b0;
        if (spacing_cfg != '0) begin
            // first slot holding the id wins; zeroed slots count as real entries
            for (int k = 0; k < rrl_pkg::SERVICE_SLOTS; k++) begin
                if (!hit && seen_id[k] == id) begin
                    gap = stamp - seen_at[k];
                    // too soon: table, window and count all stay as they are
                    if (gap < rrl_pkg::TIME_W'(spacing_cfg))
                        return rrl_pkg::VERDICT_SPACING;
                    seen_at[k] = stamp;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                seen_id[next_slot] = id;
                seen_at[next_slot] = stamp;
                next_slot = (next_slot == rrl_pkg::SLOT_IDX_W'(rrl_pkg::SERVICE_SLOTS - 1)) ?
                            '0 : next_slot + 1'b1;
            end
        end
        if (cap_cfg != '0) begin
            // modulo-2^32 elapsed time; a backwards tick looks like a long wait
            if (stamp - win_start > rrl_pkg::WINDOW_MS) begin
                win_start = stamp;
                win_count = '0;
            end
            if (win_count != rrl_pkg::COUNT_MAX)
                win_count = win_count + 1'b1;
            if (win_count > rrl_pkg::COUNT_W'(cap_cfg))
                return rrl_pkg::VERDICT_CAP;
        end
        return rrl_pkg::VERDICT_ACCEPT;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge, predicts on request beats,
    // checks verdict beats in order
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch_beats
        rrl_pkg::t_verdict want;
        if (!rst_n) begin
            for (int k = 0; k < rrl_pkg::SERVICE_SLOTS; k++) begin
                seen_id[k] = '0;
                seen_at[k] = '0;
            end
            next_slot      = '0;
            win_start      = '0;
            win_count      = '0;
            spacing_cfg    = '0;
            cap_cfg        = '0;
            req_beat_taken = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rrl_pkg::CFG_MIN_SPACING:
                        spacing_cfg = cfg_data[rrl_pkg::SPACING_W-1:0];
                    rrl_pkg::CFG_MAX_PER_SECOND:
                        cap_cfg     = cfg_data[rrl_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end
            req_beat_taken = in_valid && !in_stall;
            if (req_beat_taken)
                verdict_q.push_back(judge_request(in_id, in_stamp));
            if (out_valid && !out_stall) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: verdict %0d with none expected", $time, verdict);
                end else begin
                    want = verdict_q.pop_front();
                    if (verdict !== want) begin
                        mismatches++;
                        $display("%0t: verdict expected %0d, got %0d", $time, want, verdict);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: moves on the falling edge. Request beats come from pending_q
    // with optional gaps; the verdict side stalls in random bursts.
    // ------------------------------------------------------------------
    int unsigned send_gap  = 0;
    int unsigned stall_left = 0;

    always @(negedge clk) begin : drive_beats
        t_req nxt;
        logic drive_valid;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            // a held beat stays put until taken; only then pick the next one
            if (!in_valid || req_beat_taken) begin
                drive_valid = 1'b0;
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending_q.size() != 0) begin
                    nxt = pending_q.pop_front();
                    drive_valid = 1'b1;
                    in_id    <= nxt.id;
                    in_stamp <= nxt.stamp;
                    if (sender_idles && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 7);
                end
                in_valid <= drive_valid;
            end
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_req(input logic [rrl_pkg::ID_W-1:0] id,
                                     input logic [rrl_pkg::TIME_W-1:0] stamp);
        pending_q.push_back('{id: id, stamp: stamp});
        reqs_queued++;
    endfunction

    // Wait for every verdict, then allow the block's worst-case walk plus
    // margin before a register write.
    task automatic wait_drained();
        while (reqs_queued != verdicts_seen)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input rrl_pkg::t_cfg_index idx,
                             input logic [rrl_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Set both registers; junk in the unused upper bits of the cap write must be dropped.
    task automatic set_limits(input logic [rrl_pkg::SPACING_W-1:0] spacing,
                              input logic [rrl_pkg::CAP_W-1:0] cap);
        write_reg(rrl_pkg::CFG_MIN_SPACING, spacing);
        write_reg(rrl_pkg::CFG_MAX_PER_SECOND, {6'($urandom), cap});
    endtask

    // Mostly a small pool of services on a forward-moving clock, so slots get
    // hit, refreshed and evicted; the rest is random ids and random times.
    task automatic run_traffic(input int n, input int step_max, input int pool_n,
                               input int noise_pct);
        logic [rrl_pkg::ID_W-1:0] pool [16];
        foreach (pool[k])
            pool[k] = rrl_pkg::ID_W'($urandom);
        repeat (n) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                push_req(rrl_pkg::ID_W'($urandom), $urandom);
            end else begin
                tick = tick + $urandom_range(0, step_max);
                push_req(pool[$urandom_range(0, pool_n - 1)], tick);
            end
        end
    endtask

    task automatic run_phase(input logic [rrl_pkg::SPACING_W-1:0] spacing,
                             input logic [rrl_pkg::CAP_W-1:0] cap,
                             input int n, input int step_max, input int pool_n,
                             input int noise_pct, input logic s_idle, input logic r_idle);
        wait_drained();
        set_limits(spacing, cap);
        sender_idles   = s_idle;
        receiver_idles = r_idle;
        run_traffic(n, step_max, pool_n, noise_pct);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        // Registers at reset: both checks off, everything accepted.
        push_req(16'h0000, 32'h0000_0000);
        push_req(16'hFFFF, 32'hFFFF_FFFF);
        wait_drained();

        // Spacing on. The cleared table makes id 0 a hit in slot 0 right away.
        write_reg(rrl_pkg::CFG_MIN_SPACING, 16'd100);
        push_req(16'h0000, 32'd50);           // gap 50 < 100: spacing reject
        push_req(16'h0000, 32'd100);          // gap exactly 100: accepted, refreshed
        push_req(16'h1234, 32'd10);           // new id lands on slot 0
        push_req(16'h1234, 32'd20);
        push_req(16'hABCD, 32'hFFFF_FFF0);
        push_req(16'hABCD, 32'h0000_0010);    // gap across the 2^32 wrap is short
        push_req(16'hABCD, 32'h0000_0060);
        push_req(16'hABCD, 32'h0000_0010);    // tick goes backwards: huge gap
        wait_drained();

        // Widest spacing, tightest cap; spacing rejects leave the window alone.
        set_limits(16'hFFFF, 10'd1);
        push_req(16'h5555, 32'd1000);         // elapsed exactly 1000: same window
        push_req(16'hAAAA, 32'd1500);         // elapsed 1500: new window, accepted
        push_req(16'h5555, 32'd2001);         // spacing reject, count untouched
        push_req(16'h7777, 32'd2001);         // elapsed 501: second in window, cap reject
        wait_drained();

        // Smallest spacing, widest cap.
        set_limits(16'd1, 10'h3FF);
        push_req(16'h0F0F, 32'h8000_0000);
        push_req(16'h0F0F, 32'h8000_0000);    // gap 0 < 1
        push_req(16'h0F0F, 32'h8000_0001);
        push_req(16'hF0F0, 32'h7FFF_FFFF);

        // Random part; the clock starts close to the wrap so it crosses zero.
        tick = 32'hFFFF_0000;
        run_phase(16'd0,     10'd5,    150, 200, 10, 10, 1'b1, 1'b1);
        run_phase(16'd50,    10'd0,    150,  60,  6, 10, 1'b1, 1'b0);
        run_phase(16'd100,   10'd3,    150,  80, 12, 10, 1'b0, 1'b1);
        run_phase(16'hFFFF,  10'h3FF,  120,  30,  9, 10, 1'b1, 1'b1);
        run_phase(16'd1,     10'd1,    150, 400,  4, 10, 1'b0, 1'b0);
        run_phase(rrl_pkg::SPACING_W'($urandom_range(1, 300)),
                  rrl_pkg::CAP_W'($urandom_range(1, 20)),
                  150, 150, 10, 15, 1'b1, 1'b1);
        run_phase(16'd30,    10'd8,    150,  50, 16, 10, 1'b1, 1'b1);
        run_phase(16'd0,     10'd0,     80, 100,  8, 30, 1'b1, 1'b1);

        // Final stretch without idling: 100 requests in one window run well
        // past a cap of 40, so the tail is all cap rejects.
        wait_drained();
        set_limits(16'd0, 10'd40);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        tick = tick + 32'd5000;
        repeat (100) begin
            if ($urandom_range(0, 9) == 0)
                tick = tick + 1'b1;
            push_req(rrl_pkg::ID_W'($urandom), tick);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
